FILE: rtl/core/sfsur_pkg.sv
// Types, ring constants and pointer helpers for the sensor sample unpack ring.
// Depends on nothing; imported by sensor_fifo_sample_unpack_ring.
package sfsur_pkg;

	localparam int RING_DEPTH = 32;
	localparam int RING_AW    = $clog2(RING_DEPTH);
	localparam int PTR_W1     = RING_AW + 1;
	localparam int SAMPLE_W   = 18;
	localparam int COUNT_W    = 5;
	localparam int CHAN_W     = 2;

	typedef logic [RING_AW-1:0]  ring_ptr_t;
	typedef logic [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic       action;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic               record_done;
		logic [COUNT_W-1:0] available_count;
		sample_t            newest_red;
		sample_t            newest_ir;
		sample_t            newest_green;
		sample_t            oldest_red;
		sample_t            oldest_ir;
		sample_t            oldest_green;
	} result_t;

	// One stored record: one sample per LED channel
	typedef struct packed {
		sample_t red;
		sample_t ir;
		sample_t green;
	} record_t;

	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_POP  = 1'b1;

	function automatic ring_ptr_t ring_next(input ring_ptr_t i);
		return (i == RING_AW'(RING_DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	// head minus tail, modulo ring depth
	function automatic ring_ptr_t ring_count(input ring_ptr_t h, input ring_ptr_t t);
		logic [PTR_W1-1:0] d;
		d = {1'b0, h} - {1'b0, t};
		if (h < t)
			d = d + PTR_W1'(RING_DEPTH);
		return d[RING_AW-1:0];
	endfunction

endpackage

FILE: rtl/core/sfsur_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module sfsur_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem_q[rd_addr];
	end

endmodule

FILE: rtl/core/sensor_fifo_sample_unpack_ring.sv
// Top level of the sensor sample unpack ring: byte assembly, pointers, result stage.
// Depends on sfsur_pkg and sfsur_ram.
//
// Takes raw sensor FIFO bytes, one per item transfer, and joins each run of three
// (MSB first, low 18 bits kept) into a sample. Samples fill red, IR, green in turn
// up to active_channels per record (0 behaves as 1); channels above the last one
// written read as zero. A completed record is stored in a 32-slot ring at head+1
// and head moves onto it; a pop item moves tail on if any record is unread. Each
// item gives exactly one result transfer: record_done, the unread count, the record
// at head and the record at tail+1 (the latter zero when nothing is unread). Overrun is not
// checked: a record completing on a full ring discards the unread ones.
// Throughput is one item per clock when item_stall is low. The result is registered
// in stage 1 and then in the output register; stage 1 is the registered read port
// of the ring RAM.
// Up to two results are held internally, so a stalled output blocks the input only
// once both are full. The ring needs no clearing pass after reset: only written slots
// ever reach the result. active_channels (reset value 1) is written through cfg_wr_en /
// cfg_wr_data; the user must do so only while the block is idle, as the block leaves it unchecked.
module sensor_fifo_sample_unpack_ring (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [sfsur_pkg::CHAN_W-1:0]      cfg_wr_data,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  sfsur_pkg::item_t                  item,
	output logic                              result_valid,
	input  logic                              result_stall,
	output sfsur_pkg::result_t                result
);
	import sfsur_pkg::*;

	// byte position within a sample
	localparam logic [1:0] PH_B0 = 2'd0;
	localparam logic [1:0] PH_B1 = 2'd1;
	localparam logic [1:0] PH_B2 = 2'd2;

	localparam logic [CHAN_W-1:0] ACT_CH_RESET = CHAN_W'(1);

	// Architectural state
	logic [CHAN_W-1:0] active_channels_q;
	logic [1:0]        byte_phase_q;
	logic [CHAN_W-1:0] channel_index_q;
	logic [15:0]       partial_bits_q;
	ring_ptr_t         head_q, tail_q;
	sample_t           asm_red_q, asm_ir_q;   // samples of the record in progress
	record_t           newest_q;              // mirror of the slot at head

	// Next-state values
	logic [1:0]        byte_phase_d;
	logic [CHAN_W-1:0] channel_index_d;
	logic [15:0]       partial_bits_d;
	ring_ptr_t         head_d, tail_d;
	sample_t           asm_red_d, asm_ir_d;
	record_t           newest_d;

	logic              accept;
	logic              rec_done;
	logic              last_chan;
	logic [CHAN_W-1:0] chans;
	sample_t           sample;
	ring_ptr_t         wr_slot, rd_slot, avail_d;
	record_t           wr_rec;

	// Stage 1 (RAM read in flight) and output register
	logic              valid_s1;
	logic              done_s1;
	ring_ptr_t         avail_s1;
	record_t           newest_s1;
	logic              byp_s1;
	record_t           byp_rec_s1;
	record_t           rd_rec;
	record_t           oldest;
	logic              s1_move;
	logic              out_valid_q;
	result_t           out_q;

	assign accept  = item_valid && !item_stall;
	assign s1_move = valid_s1 && (!out_valid_q || !result_stall);
	assign item_stall = valid_s1 && !s1_move;

	assign chans   = (active_channels_q == '0) ? CHAN_W'(1) : active_channels_q;
	assign sample  = {partial_bits_q[9:0], item.data_byte};
	assign wr_slot = ring_next(head_q);
	assign last_chan = ((CHAN_W + 1)'(channel_index_q) + 1'b1 >= {1'b0, chans})
		|| (channel_index_q >= CHAN_W'(2));

	// Assembly and pointer update for one item
	always_comb begin
		byte_phase_d    = byte_phase_q;
		channel_index_d = channel_index_q;
		partial_bits_d  = partial_bits_q;
		head_d          = head_q;
		tail_d          = tail_q;
		asm_red_d       = asm_red_q;
		asm_ir_d        = asm_ir_q;
		newest_d        = newest_q;
		rec_done        = 1'b0;
		wr_rec          = '0;

		if (item.action == ACT_PUSH) begin
			unique case (byte_phase_q)
				PH_B1: begin
					partial_bits_d = {partial_bits_q[7:0], item.data_byte};
					byte_phase_d   = PH_B2;
				end
				PH_B2: begin
					byte_phase_d = PH_B0;
					if (channel_index_q == CHAN_W'(0))
						asm_red_d = sample;
					else if (channel_index_q == CHAN_W'(1))
						asm_ir_d = sample;
					if (last_chan) begin
						// channels above the one just written are cleared
						wr_rec.red   = (channel_index_q == CHAN_W'(0)) ? sample : asm_red_q;
						wr_rec.ir    = (channel_index_q == CHAN_W'(1)) ? sample :
							(channel_index_q > CHAN_W'(1)) ? asm_ir_q : '0;
						wr_rec.green = (channel_index_q >= CHAN_W'(2)) ? sample : '0;
						rec_done        = 1'b1;
						newest_d        = wr_rec;
						channel_index_d = '0;
						head_d          = wr_slot;
					end else begin
						channel_index_d = channel_index_q + 1'b1;
					end
				end
				default: begin
					partial_bits_d = {8'd0, item.data_byte};
					byte_phase_d   = PH_B1;
				end
			endcase
		end else if (ring_count(head_q, tail_q) != '0) begin
			tail_d = ring_next(tail_q);
		end
	end

	assign avail_d = ring_count(head_d, tail_d);
	assign rd_slot = ring_next(tail_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_channels_q <= ACT_CH_RESET;
			byte_phase_q      <= PH_B0;
			channel_index_q   <= '0;
			partial_bits_q    <= '0;
			head_q            <= '0;
			tail_q            <= '0;
			asm_red_q         <= '0;
			asm_ir_q          <= '0;
			newest_q          <= '0;
		end else begin
			if (cfg_wr_en)
				active_channels_q <= cfg_wr_data;
			if (accept) begin
				byte_phase_q    <= byte_phase_d;
				channel_index_q <= channel_index_d;
				partial_bits_q  <= partial_bits_d;
				head_q          <= head_d;
				tail_q          <= tail_d;
				asm_red_q       <= asm_red_d;
				asm_ir_q        <= asm_ir_d;
				newest_q        <= newest_d;
			end
		end
	end

	// Whole records go into the ring at completion; oldest is read at tail+1
	sfsur_ram #(
		.WIDTH ($bits(record_t)),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk     (clk),
		.wr_en   (accept && rec_done),
		.wr_addr (wr_slot),
		.wr_data (wr_rec),
		.rd_en   (accept),
		.rd_addr (rd_slot),
		.rd_data (rd_rec)
	);

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (s1_move)
			valid_s1 <= 1'b0;
	end

	// Stage 1 payload; bypass covers a record written to the slot being read
	always_ff @(posedge clk) begin
		if (accept) begin
			done_s1    <= rec_done;
			avail_s1   <= avail_d;
			newest_s1  <= newest_d;
			byp_s1     <= rec_done && (wr_slot == rd_slot);
			byp_rec_s1 <= wr_rec;
		end
	end

	assign oldest = (avail_s1 == '0) ? '0 : (byp_s1 ? byp_rec_s1 : rd_rec);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s1_move)
			out_valid_q <= 1'b1;
		else if (!result_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_q.record_done     <= done_s1;
			out_q.available_count <= COUNT_W'(avail_s1);
			out_q.newest_red      <= newest_s1.red;
			out_q.newest_ir       <= newest_s1.ir;
			out_q.newest_green    <= newest_s1.green;
			out_q.oldest_red      <= oldest.red;
			out_q.oldest_ir       <= oldest.ir;
			out_q.oldest_green    <= oldest.green;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// Checks
	a_stall_needs_backlog: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && out_valid_q))
		else $error("input stalled without a full result path");

	a_head_on_record: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && rec_done) |=> (head_q == $past(wr_slot)))
		else $error("head did not move onto the stored record");

	a_pop_moves_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.action == ACT_POP && head_q != tail_q) |=> (tail_q != $past(tail_q)))
		else $error("pop on a non-empty ring left tail in place");

	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		channel_index_q <= CHAN_W'(2))
		else $error("channel index beyond green");

	a_done_clears_chan: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && rec_done) |=> (channel_index_q == '0 && byte_phase_q == PH_B0))
		else $error("record completion left assembly state behind");

endmodule
